// ----- sv/rasr_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the rational add/subtract/reduce block
// no dependencies; imported by every module of the block

package rasr_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_WIDTH     = 32;
    localparam int RES_DEN_WIDTH     = 30;
    localparam int VALUE_WIDTH_CAP   = 64;

    // width that holds a cross-multiplied sum exactly, capped like the datapath wraps
    function automatic int value_width(input int w);
        int full;
        full = 2 * w + 1;
        return (full > VALUE_WIDTH_CAP) ? VALUE_WIDTH_CAP : full;
    endfunction

    localparam int VALUE_WIDTH_DEF = value_width(OPERAND_WIDTH_DEF);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_SUB    = 2'd1,
        CMD_REDUCE = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MAG,
        ST_GCD_GO,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN
    } state_t;

endpackage

// ----- sv/rasr_gcd.sv -----
`timescale 1ns / 1ps
// binary gcd unit, one compare/subtract or halving step per cycle
// depends on rasr_pkg

module rasr_gcd #(
    parameter int WIDTH = rasr_pkg::VALUE_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    output logic             done,
    output logic [WIDTH-1:0] g
);
    import rasr_pkg::*;

    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [KW-1:0]    k_reg;
    logic [WIDTH-1:0] g_reg;
    logic             run_reg;
    logic             done_reg;

    logic [WIDTH:0]   diff_ab;
    logic [WIDTH-1:0] diff_ba;
    logic             finish;

    assign diff_ab = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba = b_reg - a_reg;
    assign finish  = run_reg && ((a_reg == b_reg) || (a_reg == '0) || (b_reg == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (finish)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= x;
            b_reg <= y;
            k_reg <= '0;
        end
        else if (finish)
        begin
            // equal operands or one of them zero: the other one carries the odd part
            g_reg <= (a_reg | b_reg) << k_reg;
        end
        else if (run_reg)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (!diff_ab[WIDTH])
            begin
                // both odd: difference is even, halve it right away
                a_reg <= diff_ab[WIDTH-1:0] >> 1;
            end
            else
            begin
                b_reg <= diff_ba >> 1;
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ----- sv/rasr_div.sv -----
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
// depends on rasr_pkg

module rasr_div #(
    parameter int WIDTH = rasr_pkg::VALUE_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);
    import rasr_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH+1:0] diff;
    logic             ge;
    logic             last;

    assign rem_sh = {rem_reg, quo_reg[WIDTH-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = !diff[WIDTH+1];
    assign last   = run_reg && (cnt_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (last)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= CW'(WIDTH);
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so it fits back in WIDTH bits
            rem_reg <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/rational_add_sub_reduce.sv -----
`timescale 1ns / 1ps
// top level: sequencer, shared multiplier, sign handling and result register
// depends on rasr_pkg, rasr_gcd, rasr_div

// Adds or subtracts two signed fractions, or takes the first one alone, and
// returns the result in lowest terms with a non-negative denominator; 0/0 comes
// back as 0/0 with zero_over_zero set. A command is taken when start is high
// and busy is low; busy then stays high until the result beat, which shows on
// the result ports for the single cycle that done is high and cannot be held
// off. The binary gcd loop and the two exact divisions by the gcd work on
// SW = 2*OPERAND_WIDTH+1 bits (at most 64); the divisions run one after the other
// through one shift-subtract divider. Reduce commands skip the multiply states.

module rational_add_sub_reduce #(
    parameter int OPERAND_WIDTH = rasr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              cmd,
    input  logic signed [OPERAND_WIDTH-1:0]         a_num,
    input  logic signed [OPERAND_WIDTH-1:0]         a_den,
    input  logic signed [OPERAND_WIDTH-1:0]         b_num,
    input  logic signed [OPERAND_WIDTH-1:0]         b_den,
    output logic                                    done,
    output logic signed [rasr_pkg::RES_NUM_WIDTH-1:0] res_num,
    output logic [rasr_pkg::RES_DEN_WIDTH-1:0]      res_den,
    output logic                                    zero_over_zero
);
    import rasr_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = value_width(W);
    localparam int XW = (SW > RES_NUM_WIDTH) ? SW : RES_NUM_WIDTH;

    state_t state_reg;
    state_t state_next;

    logic signed [W-1:0]  an_reg;
    logic signed [W-1:0]  ad_reg;
    logic signed [W-1:0]  bn_reg;
    logic signed [W-1:0]  bd_reg;
    logic                 sub_reg;
    logic signed [PW-1:0] mul_reg;
    logic signed [PW-1:0] p0_reg;
    logic signed [SW-1:0] num_reg;
    logic signed [SW-1:0] den_reg;
    logic [SW-1:0]        mn_reg;
    logic [SW-1:0]        md_reg;
    logic                 neg_reg;
    logic [SW-1:0]        rn_reg;

    logic                          done_reg;
    logic                          zoz_reg;
    logic [RES_NUM_WIDTH-1:0]      res_num_reg;
    logic [RES_DEN_WIDTH-1:0]      res_den_reg;

    logic signed [W-1:0]  mul_x;
    logic signed [W-1:0]  mul_y;
    logic signed [PW-1:0] mul_prod;

    logic [SW-1:0] num_bits;
    logic [SW-1:0] den_bits;
    logic [SW-1:0] num_mag;
    logic [SW-1:0] den_mag;

    logic          gcd_start;
    logic          gcd_done;
    logic [SW-1:0] gcd_g;
    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic          div_done;
    logic [SW-1:0] div_quo;

    logic          fin_zoz;
    logic          fin_res;

    logic [XW-1:0] rn_x;
    logic [XW-1:0] num_x;
    logic [XW-1:0] den_x;

    // one multiplier, fed per state
    always_comb
    begin
        case (state_reg)
            ST_MUL0:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
            ST_MUL1:
            begin
                mul_x = ad_reg;
                mul_y = bn_reg;
            end
            default:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign mul_prod = mul_x * mul_y;

    assign num_bits = num_reg;
    assign den_bits = den_reg;
    assign num_mag  = num_bits[SW-1] ? (SW'(0) - num_bits) : num_bits;
    assign den_mag  = den_bits[SW-1] ? (SW'(0) - den_bits) : den_bits;

    always_comb
    begin
        state_next   = state_reg;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = mn_reg;
        fin_zoz      = 1'b0;
        fin_res      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd inside {CMD_ADD, CMD_SUB}) ? ST_MUL0 : ST_MAG;
                end
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_MAG;
            ST_MAG:
            begin
                if ((num_reg == '0) && (den_reg == '0))
                begin
                    fin_zoz    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_GCD_GO;
                end
            end
            ST_GCD_GO:
            begin
                gcd_start  = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = mn_reg;
                    state_next   = ST_DIV_NUM;
                end
            end
            ST_DIV_NUM:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = md_reg;
                    state_next   = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN:
            begin
                if (div_done)
                begin
                    fin_res    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin_zoz | fin_res;
        end
    end

    // sign goes on the numerator, then both fields wrap to their port widths
    assign rn_x  = XW'(rn_reg);
    assign num_x = neg_reg ? (XW'(0) - rn_x) : rn_x;
    assign den_x = XW'(div_quo);

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_prod;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    an_reg  <= a_num;
                    ad_reg  <= a_den;
                    bn_reg  <= b_num;
                    bd_reg  <= b_den;
                    sub_reg <= (cmd == CMD_SUB);
                    num_reg <= SW'(a_num);
                    den_reg <= SW'(a_den);
                end
            end
            ST_MUL1: p0_reg <= mul_reg;
            ST_MUL2:
            begin
                num_reg <= sub_reg ? (SW'(p0_reg) - SW'(mul_reg))
                                   : (SW'(p0_reg) + SW'(mul_reg));
            end
            ST_MUL3: den_reg <= SW'(mul_reg);
            ST_MAG:
            begin
                mn_reg  <= num_mag;
                md_reg  <= den_mag;
                neg_reg <= num_reg[SW-1] ^ den_reg[SW-1];
            end
            ST_DIV_NUM:
            begin
                if (div_done)
                begin
                    rn_reg <= div_quo;
                end
            end
            default:
            begin
            end
        endcase
        if (fin_zoz)
        begin
            res_num_reg <= '0;
            res_den_reg <= '0;
            zoz_reg     <= 1'b1;
        end
        else if (fin_res)
        begin
            res_num_reg <= num_x[RES_NUM_WIDTH-1:0];
            res_den_reg <= den_x[RES_DEN_WIDTH-1:0];
            zoz_reg     <= 1'b0;
        end
    end

    rasr_gcd #(
        .WIDTH (SW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (mn_reg),
        .y     (md_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rasr_div #(
        .WIDTH (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign res_num        = res_num_reg;
    assign res_den        = res_den_reg;
    assign zero_over_zero = zoz_reg;

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result beat without a command in flight");

    a_zoz_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_over_zero |-> (res_num == '0) && (res_den == '0))
        else $error("zero over zero result is not 0/0");

    a_gcd_before_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_GCD && gcd_done) || state_reg == ST_DIV_NUM)
        else $error("divider started outside the division phase");

endmodule

// ----- dv/rasr_checker.sv -----
`timescale 1ns / 1ps
// result checker for rational_add_sub_reduce: predicts each result from the command beat
// and compares it with the result beat; depends on rasr_pkg

module rasr_checker #(
    parameter int OW = rasr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic                                      busy,
    input  logic [1:0]                                cmd,
    input  logic signed [OW-1:0]                      a_num,
    input  logic signed [OW-1:0]                      a_den,
    input  logic signed [OW-1:0]                      b_num,
    input  logic signed [OW-1:0]                      b_den,
    input  logic                                      done,
    input  logic signed [rasr_pkg::RES_NUM_WIDTH-1:0] res_num,
    input  logic [rasr_pkg::RES_DEN_WIDTH-1:0]        res_den,
    input  logic                                      zero_over_zero,
    output int                                        mismatch_count,
    output int                                        pending,
    output int                                        checked_count,
    output int                                        zoz_count
);
    import rasr_pkg::*;

    typedef struct {
        logic signed [RES_NUM_WIDTH-1:0] num;
        logic [RES_DEN_WIDTH-1:0]        den;
        logic                            zoz;
    } fraction_t;

    fraction_t lowest_terms_q[$];

    function automatic fraction_t lowest_terms(input logic [1:0] op,
                                               input logic signed [OW-1:0] an,
                                               input logic signed [OW-1:0] ad,
                                               input logic signed [OW-1:0] bn,
                                               input logic signed [OW-1:0] bd);
        fraction_t   f;
        longint      xn, xd, yn, yd, sn, sd;
        logic [63:0] mn, md, x, y, r, qn, qd;
        bit          neg;
        xn = an;
        xd = ad;
        yn = bn;
        yd = bd;
        if (op == CMD_ADD)
        begin
            sn = xn * yd + xd * yn;
            sd = xd * yd;
        end
        else if (op == CMD_SUB)
        begin
            sn = xn * yd - xd * yn;
            sd = xd * yd;
        end
        else
        begin
            // the unused code 3 behaves as reduce
            sn = xn;
            sd = xd;
        end
        if (sn == 0 && sd == 0)
        begin
            f.num = '0;
            f.den = '0;
            f.zoz = 1'b1;
            return f;
        end
        mn = (sn < 0) ? 64'(-sn) : 64'(sn);
        md = (sd < 0) ? 64'(-sd) : 64'(sd);
        x = mn;
        y = md;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        qn = mn / x;
        qd = md / x;
        neg = (sn < 0) != (sd < 0);
        if (neg)
            qn = -qn;
        f.num = qn[RES_NUM_WIDTH-1:0];
        f.den = qd[RES_DEN_WIDTH-1:0];
        f.zoz = 1'b0;
        return f;
    endfunction

    always @(posedge clk)
    begin
        fraction_t want;
        int        errs;
        int        pushed;
        int        popped;
        errs = 0;
        pushed = 0;
        popped = 0;
        if (!rst_n)
        begin
            lowest_terms_q.delete();
            mismatch_count <= 0;
            pending <= 0;
            checked_count <= 0;
            zoz_count <= 0;
        end
        else
        begin
            // the result beat belongs to an earlier command, so it is checked first
            if (done)
            begin
                if (lowest_terms_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding: res_num %0d res_den %0d %s %0b",
                           res_num, res_den, "zero_over_zero", zero_over_zero);
                    errs++;
                end
                else
                begin
                    want = lowest_terms_q.pop_front();
                    popped = 1;
                    if (res_num !== want.num)
                    begin
                        $error("res_num: expected %0d, got %0d", want.num, res_num);
                        errs++;
                    end
                    if (res_den !== want.den)
                    begin
                        $error("res_den: expected %0d, got %0d", want.den, res_den);
                        errs++;
                    end
                    if (zero_over_zero !== want.zoz)
                    begin
                        $error("zero_over_zero: expected %0b, got %0b",
                               want.zoz, zero_over_zero);
                        errs++;
                    end
                    checked_count <= checked_count + 1;
                    if (want.zoz)
                        zoz_count <= zoz_count + 1;
                end
            end
            if (start && !busy)
            begin
                lowest_terms_q.push_back(lowest_terms(cmd, a_num, a_den, b_num, b_den));
                pushed = 1;
            end
            mismatch_count <= mismatch_count + errs;
            pending <= pending + pushed - popped;
        end
    end

endmodule

// ----- dv/tb_rational_add_sub_reduce.sv -----
`timescale 1ns / 1ps
// testbench top for rational_add_sub_reduce: directed and random command beats in bursts
// depends on rasr_pkg, the block and rasr_checker

module tb_rational_add_sub_reduce;
    import rasr_pkg::*;

    localparam int         OW            = OPERAND_WIDTH_DEF;
    localparam int         RANDOM_ITEMS  = 1450;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         DRAIN_CYCLES  = 160;
    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         OP_MAX        = 32767;
    localparam int         OP_MIN        = -32768;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      cmd;
    logic signed [OW-1:0]            a_num;
    logic signed [OW-1:0]            a_den;
    logic signed [OW-1:0]            b_num;
    logic signed [OW-1:0]            b_den;
    logic                            done;
    logic signed [RES_NUM_WIDTH-1:0] res_num;
    logic [RES_DEN_WIDTH-1:0]        res_den;
    logic                            zero_over_zero;

    int mismatch_count;
    int pending;
    int checked_count;
    int zoz_count;
    int idle_cycles;
    int add_sent;
    int sub_sent;
    int reduce_sent;
    int spare_sent;

    rational_add_sub_reduce #(
        .OPERAND_WIDTH(OW)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .done           (done),
        .res_num        (res_num),
        .res_den        (res_den),
        .zero_over_zero (zero_over_zero)
    );

    rasr_checker #(
        .OW(OW)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .done           (done),
        .res_num        (res_num),
        .res_den        (res_den),
        .zero_over_zero (zero_over_zero),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .zoz_count      (zoz_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // no progress on either side for too long means the block hung
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("[rational_add_sub_reduce] ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // holds start high until the beat is taken; leaves start high for the next beat
    task automatic send_command(input logic [1:0] c,
                                input int an, input int ad, input int bn, input int bd);
        start <= 1'b1;
        cmd <= c;
        a_num <= an[OW-1:0];
        a_den <= ad[OW-1:0];
        b_num <= bn[OW-1:0];
        b_den <= bd[OW-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (c)
            CMD_ADD: add_sent++;
            CMD_SUB: sub_sent++;
            CMD_REDUCE: reduce_sent++;
            default: spare_sent++;
        endcase
    endtask

    // operands biased toward shared factors so the gcd does real work
    function automatic int pick_operand(input int factor);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = 0;
            1: v = $urandom_range(0, 1) ? 1 : -1;
            2: v = int'($urandom_range(0, 32)) - 16;
            3, 4: v = factor * (int'($urandom_range(0, 400)) - 200);
            5: v = int'($urandom_range(0, 65535)) + OP_MIN;
            6: begin
                case ($urandom_range(0, 2))
                    0: v = OP_MAX;
                    1: v = -OP_MAX;
                    default: v = OP_MIN;
                endcase
            end
            default: v = int'($urandom_range(0, 2 * OP_MAX)) - OP_MAX;
        endcase
        return v;
    endfunction

    function automatic int pick_denominator(input int factor);
        int v;
        v = pick_operand(factor);
        // zero denominators stay, but rarely
        while (v == 0 && $urandom_range(0, 9) != 0)
            v = pick_operand(factor);
        return v;
    endfunction

    task automatic send_random_command;
        int         factor;
        int         sel;
        logic [1:0] c;
        factor = $urandom_range(1, 150);
        sel = $urandom_range(0, 9);
        if (sel < 4)
            c = CMD_ADD;
        else if (sel < 7)
            c = CMD_SUB;
        else if (sel < 9)
            c = CMD_REDUCE;
        else
            c = CMD_SPARE;
        send_command(c, pick_operand(factor), pick_denominator(factor),
                     pick_operand(factor), pick_denominator(factor));
    endtask

    initial
    begin
        int sent;
        int burst;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= CMD_ADD;
        a_num <= '0;
        a_den <= '0;
        b_num <= '0;
        b_den <= '0;
        add_sent = 0;
        sub_sent = 0;
        reduce_sent = 0;
        spare_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_ADD, 1, 2, 1, 3);
        send_command(CMD_SUB, 1, 2, 1, 2);
        send_command(CMD_REDUCE, 0, 0, 7, 9);
        send_command(CMD_ADD, 0, 0, 0, 0);
        send_command(CMD_ADD, 0, 5, 0, 0);
        send_command(CMD_SUB, 0, 0, 5, 3);
        send_command(CMD_ADD, 3, 0, 4, 0);
        send_command(CMD_ADD, 3, 0, 4, 5);
        send_command(CMD_REDUCE, 0, -7, 0, 0);
        send_command(CMD_REDUCE, 5, 0, 0, 0);
        send_command(CMD_REDUCE, -5, 0, 0, 0);
        send_command(CMD_REDUCE, 6, -4, 0, 0);
        send_command(CMD_REDUCE, -6, -4, 0, 0);
        send_command(CMD_REDUCE, 12345, -12345, 0, 0);
        send_command(CMD_SPARE, 10, 4, -31, 17);
        send_command(CMD_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
        send_command(CMD_SUB, -OP_MAX, OP_MAX, OP_MAX, -OP_MAX);
        send_command(CMD_ADD, OP_MAX, -OP_MAX, -OP_MAX, OP_MAX);
        send_command(CMD_ADD, 1, OP_MAX, 1, OP_MAX - 1);
        send_command(CMD_SUB, OP_MAX, 1, -OP_MAX, OP_MAX - 1);
        // most negative operand, outside the nominal range
        send_command(CMD_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
        send_command(CMD_SUB, OP_MIN, 1, 1, OP_MIN);
        send_command(CMD_REDUCE, OP_MIN, OP_MIN, 0, 0);
        send_command(CMD_REDUCE, OP_MIN, 1, 0, 0);
        send_command(CMD_SUB, OP_MIN, -1, OP_MIN, OP_MAX);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                send_random_command();
                sent++;
            end
            // a third of the bursts run straight into the next one
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 160)) @(posedge clk);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d add, %0d subtract, %0d reduce and %0d spare-code command beats",
                 add_sent, sub_sent, reduce_sent, spare_sent);
        $display("checked %0d result beats, %0d of them 0/0; %0d mismatches",
                 checked_count, zoz_count, mismatch_count);
        if (mismatch_count == 0 && pending == 0)
            $display("[rational_add_sub_reduce] OK");
        else
            $display("[rational_add_sub_reduce] ERROR");
        $finish;
    end

endmodule
